/* rtl/core/envelope_tracker_beat_detect_unit_assert.svh */
// Assertion macros for the envelope tracker beat detect unit.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef ENVELOPE_TRACKER_BEAT_DETECT_UNIT_ASSERT_SVH
`define ENVELOPE_TRACKER_BEAT_DETECT_UNIT_ASSERT_SVH

// same-cycle implication
`define ETBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("etbd assertion failed");

// next-cycle implication
`define ETBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("etbd assertion failed");

`endif

/* rtl/core/etbd_pkg.sv */
// Shared types, constants and microprogram for the envelope tracker beat detect unit.
// No dependencies.
package etbd_pkg;

    localparam int ST_W           = 32;
    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 16;
    localparam int RATE_W         = 16;
    localparam int DIFF_W         = ST_W + 1;
    localparam int PROD_W         = DIFF_W + RATE_W + 1;
    localparam int Q_W            = PROD_W - FRAC_BITS;
    localparam int SUM_W          = Q_W + 1;
    localparam int CMP_W          = ST_W + 4;
    localparam int WARM_W         = 4;
    localparam int CFG_IDX_W      = 3;

    localparam logic [WARM_W-1:0] WARMUP_SAMPLES = WARM_W'(10);
    localparam logic [WARM_W-1:0] WARM_MAX       = {WARM_W{1'b1}};

    localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
    localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GENERAL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_RISE     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FALL     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_ENVELOPE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_ENERGY   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RATE      = CFG_IDX_W'(5);

    localparam int UCODE_LEN = 9;
    localparam int STEP_W    = $clog2(UCODE_LEN);
    localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(UCODE_LEN - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          ack_beat;
    } t_in_word;

    typedef struct packed {
        logic signed [ST_W-1:0] fast_avg;
        logic signed [ST_W-1:0] slow_avg;
        logic [ST_W-2:0]        change_level;
        logic signed [ST_W-1:0] energy_level;
        logic signed [ST_W-1:0] upper_envelope;
        logic signed [ST_W-1:0] lower_envelope;
        logic                   beat;
    } t_out_word;

    typedef struct packed {
        logic [RATE_W-1:0] rate_general;
        logic [RATE_W-1:0] rate_rise;
        logic [RATE_W-1:0] rate_fall;
        logic [RATE_W-1:0] rate_envelope;
        logic [RATE_W-1:0] rate_energy;
        logic [RATE_W-1:0] inv_sample_rate;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FAST,
        OP_SLOW,
        OP_EINC,
        OP_CHANGE,
        OP_EFOL,
        OP_UPPER,
        OP_LOWER
    } t_op;

    typedef struct packed {
        t_op  issue;
        t_op  wb;
        logic skip_cold;
        logic emit;
    } t_uword;

    typedef struct packed {
        t_op  issue;
        t_op  wb;
        logic finish;
    } t_dp_ctrl;

    // multiply issued one step, written back the next
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword uw;
        uw = '{issue: OP_NONE, wb: OP_NONE, skip_cold: 1'b0, emit: 1'b0};
        case (step)
            STEP_W'(0): begin
                uw.issue = OP_FAST;
            end
            STEP_W'(1): begin
                uw.wb    = OP_FAST;
                uw.issue = OP_SLOW;
            end
            STEP_W'(2): begin
                uw.wb    = OP_SLOW;
                uw.issue = OP_EINC;
            end
            STEP_W'(3): begin
                uw.wb    = OP_EINC;
                uw.issue = OP_CHANGE;
            end
            STEP_W'(4): begin
                uw.wb    = OP_CHANGE;
                uw.issue = OP_EFOL;
            end
            STEP_W'(5): begin
                uw.wb        = OP_EFOL;
                uw.issue     = OP_UPPER;
                uw.skip_cold = 1'b1;
            end
            STEP_W'(6): begin
                uw.wb    = OP_UPPER;
                uw.issue = OP_LOWER;
            end
            STEP_W'(7): begin
                uw.wb = OP_LOWER;
            end
            default: begin
                uw.emit = 1'b1;
            end
        endcase
        return uw;
    endfunction

endpackage

/* rtl/core/etbd_seq.sv */
// Microprogram sequencer: step counter, control ROM, skip jump and emit wait.
// Depends on etbd_pkg.
module etbd_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_warm,
    input  logic               i_out_free,
    output etbd_pkg::t_dp_ctrl o_ctrl,
    output logic               o_busy
);
    import etbd_pkg::*;

    logic              r_busy;
    logic              n_busy;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;

    assign uw = ucode_rom(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = '0;
            end
        end else if (uw.emit) begin
            if (i_out_free) begin
                n_busy = 1'b0;
            end
        end else if (uw.skip_cold && !i_warm) begin
            n_step = STEP_EMIT;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    assign o_ctrl.issue  = r_busy ? uw.issue : OP_NONE;
    assign o_ctrl.wb     = r_busy ? uw.wb : OP_NONE;
    assign o_ctrl.finish = r_busy && uw.emit && i_out_free;
    assign o_busy        = r_busy;

endmodule

/* rtl/core/etbd_dp.sv */
// Datapath: tracker state, shared multiplier, saturating write-back and beat test.
// Depends on etbd_pkg.
module etbd_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etbd_pkg::t_dp_ctrl  i_ctrl,
    input  etbd_pkg::t_in_word  i_in,
    input  etbd_pkg::t_cfg      i_cfg,
    output etbd_pkg::t_out_word o_res,
    output logic                o_warm
);
    import etbd_pkg::*;

    logic signed [ST_W-1:0]   r_fast, r_slow, r_change, r_energy, r_upper, r_lower;
    logic signed [ST_W-1:0]   r_ein;
    logic [WARM_W-1:0]        r_warm;
    logic                     r_beat;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ST_W-1:0]   r_acc;

    logic signed [ST_W-1:0]   x;
    logic signed [DIFF_W-1:0] diff_fs;
    logic [DIFF_W-1:0]        abs_fs;
    logic signed [DIFF_W-1:0] d_tgt;
    logic signed [DIFF_W-1:0] tgt;
    logic signed [ST_W-1:0]   avg;
    logic signed [DIFF_W-1:0] avg_x;
    logic [RATE_W-1:0]        rate_up, rate_dn, rate;
    logic                     is_inc;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [RATE_W:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [Q_W-1:0]    prod_q;
    logic signed [SUM_W-1:0]  sum;
    logic signed [ST_W-1:0]   wb_val;
    logic signed [ST_W-1:0]   chg_new;
    logic [CMP_W-1:0]         old10, new9;

    assign x       = {i_in.sample, {FRAC_BITS{1'b0}}};
    assign diff_fs = {r_fast[ST_W-1], r_fast} - {r_slow[ST_W-1], r_slow};
    assign abs_fs  = diff_fs[DIFF_W-1] ? DIFF_W'(-diff_fs) : DIFF_W'(diff_fs);
    assign d_tgt   = (abs_fs > {1'b0, ST_MAX}) ? {1'b0, ST_MAX} : abs_fs;

    always_comb begin
        tgt     = '0;
        avg     = '0;
        rate_up = '0;
        rate_dn = '0;
        is_inc  = 1'b0;
        case (i_ctrl.issue)
            OP_FAST: begin
                tgt = DIFF_W'(x); avg = r_fast;
                rate_up = i_cfg.rate_general; rate_dn = i_cfg.rate_general;
            end
            OP_SLOW: begin
                tgt = DIFF_W'(x); avg = r_slow;
                rate_up = i_cfg.rate_rise; rate_dn = i_cfg.rate_fall;
            end
            OP_EINC: begin
                avg = r_energy; is_inc = 1'b1;
            end
            OP_CHANGE: begin
                tgt = d_tgt; avg = r_change;
                rate_up = i_cfg.rate_general; rate_dn = i_cfg.rate_fall;
            end
            OP_EFOL: begin
                avg = r_ein;
                rate_up = i_cfg.rate_rise; rate_dn = i_cfg.rate_energy;
            end
            OP_UPPER: begin
                tgt = DIFF_W'(r_fast); avg = r_upper;
                rate_up = i_cfg.rate_general; rate_dn = i_cfg.rate_envelope;
            end
            OP_LOWER: begin
                tgt = DIFF_W'(r_fast); avg = r_lower;
                rate_up = i_cfg.rate_envelope; rate_dn = i_cfg.rate_general;
            end
            default: begin
                tgt = '0;
            end
        endcase
    end

    assign avg_x = DIFF_W'(avg);
    assign mul_a = is_inc ? DIFF_W'(r_fast) : tgt - avg_x;
    assign rate  = is_inc ? i_cfg.inv_sample_rate : ((tgt > avg_x) ? rate_up : rate_dn);
    assign mul_b = {1'b0, rate};
    assign prod  = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue != OP_NONE) begin
            r_prod <= prod;
            r_acc  <= avg;
        end
    end

    // floor by arithmetic shift, then saturate to the state width
    assign prod_q = r_prod[PROD_W-1:FRAC_BITS];
    assign sum    = SUM_W'(r_acc) + SUM_W'(prod_q);

    always_comb begin
        if ((&sum[SUM_W-1:ST_W-1]) || !(|sum[SUM_W-1:ST_W-1])) begin
            wb_val = sum[ST_W-1:0];
        end else if (sum[SUM_W-1]) begin
            wb_val = ST_MIN;
        end else begin
            wb_val = ST_MAX;
        end
    end

    assign chg_new = wb_val[ST_W-1] ? '0 : wb_val;
    assign old10   = (CMP_W'(unsigned'(r_change)) << 3) + (CMP_W'(unsigned'(r_change)) << 1);
    assign new9    = (CMP_W'(unsigned'(chg_new)) << 3) + CMP_W'(unsigned'(chg_new));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast   <= '0;
            r_slow   <= '0;
            r_change <= '0;
            r_energy <= '0;
            r_upper  <= '0;
            r_lower  <= '0;
            r_warm   <= '0;
            r_beat   <= 1'b0;
        end else begin
            case (i_ctrl.wb)
                OP_FAST:   r_fast   <= wb_val;
                OP_SLOW:   r_slow   <= wb_val;
                OP_CHANGE: begin
                    r_change <= chg_new;
                    if (old10 < new9) begin
                        r_beat <= 1'b1;
                    end
                end
                OP_EFOL:   r_energy <= wb_val;
                OP_UPPER:  r_upper  <= wb_val;
                OP_LOWER:  r_lower  <= wb_val;
                default: begin
                end
            endcase
            if (i_ctrl.finish) begin
                if (r_warm != WARM_MAX) begin
                    r_warm <= r_warm + 1'b1;
                end
                if (i_in.ack_beat) begin
                    r_beat <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wb == OP_EINC) begin
            r_ein <= wb_val;
        end
    end

    assign o_warm = r_warm > WARMUP_SAMPLES;

    assign o_res.fast_avg       = r_fast;
    assign o_res.slow_avg       = r_slow;
    assign o_res.change_level   = r_change[ST_W-2:0];
    assign o_res.energy_level   = r_energy;
    assign o_res.upper_envelope = r_upper;
    assign o_res.lower_envelope = r_lower;
    assign o_res.beat           = r_beat;

endmodule

/* rtl/core/envelope_tracker_beat_detect_unit.sv */
// Envelope tracker with beat detection: one sample in, one set of averages out.
// An accepted item keeps the unit busy until its result is loaded; a 9-step
// microprogram runs all seven updates through one shared 33x17 multiplier with
// one write-back stage; the first 11 samples skip the upper and lower envelope
// updates. The next sample is taken the cycle after the result is loaded into
// the output register; a result held by o_out_valid/i_out_stall does not block
// that until the next result is due. The user must write rates via the i_cfg_*
// port only while idle; not enforced. Depends on etbd_pkg, etbd_seq, etbd_dp.
module envelope_tracker_beat_detect_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  etbd_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output etbd_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [etbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [etbd_pkg::RATE_W-1:0]         i_cfg_data
);
    import etbd_pkg::*;

    `include "envelope_tracker_beat_detect_unit_assert.svh"

    t_cfg      r_cfg;
    t_in_word  r_in;
    t_out_word r_out;
    logic      r_out_valid;
    logic      accept;
    logic      out_free;
    logic      busy;
    logic      warm;
    t_dp_ctrl  ctrl;
    t_out_word res;

    assign accept   = i_in_valid && !busy;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_general    <= RATE_W'(6554);
            r_cfg.rate_rise       <= RATE_W'(7);
            r_cfg.rate_fall       <= RATE_W'(1);
            r_cfg.rate_envelope   <= RATE_W'(1);
            r_cfg.rate_energy     <= RATE_W'(66);
            r_cfg.inv_sample_rate <= RATE_W'(2184);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RATE_GENERAL:  r_cfg.rate_general    <= i_cfg_data;
                CFG_RATE_RISE:     r_cfg.rate_rise       <= i_cfg_data;
                CFG_RATE_FALL:     r_cfg.rate_fall       <= i_cfg_data;
                CFG_RATE_ENVELOPE: r_cfg.rate_envelope   <= i_cfg_data;
                CFG_RATE_ENERGY:   r_cfg.rate_energy     <= i_cfg_data;
                CFG_INV_RATE:      r_cfg.inv_sample_rate <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_word;
        end
        if (ctrl.finish) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    etbd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_warm     (warm),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_busy     (busy)
    );

    etbd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_in    (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res),
        .o_warm  (warm)
    );

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `ETBD_ASSERT_NEXT(a_accept_busy, accept, busy)
    `ETBD_ASSERT_NEXT(a_finish_out, ctrl.finish, o_out_valid && !busy)
    `ETBD_ASSERT_NOW(a_idle_quiet, !busy, ctrl.issue == OP_NONE && ctrl.wb == OP_NONE && !ctrl.finish)

endmodule

/* verif/envelope_tracker_beat_detect_unit_test.sv */
// Self-checking testbench for envelope_tracker_beat_detect_unit: directed, rate-extreme and
// random sample streams, checked word by word against an in-bench fixed-point predictor.
// Depends on etbd_pkg and the unit's RTL only.
module envelope_tracker_beat_detect_unit_test;
    import etbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_GAP   = 4;
    localparam int BEAT_OLD_SCALE = 10;
    localparam int BEAT_NEW_SCALE = 9;
    localparam int SAMPLE_MAX  = 32767;
    localparam int SAMPLE_MIN  = -32768;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);
    localparam t_cfg RATE_DEFAULTS = '{
        rate_general: 16'd6554, rate_rise: 16'd7, rate_fall: 16'd1,
        rate_envelope: 16'd1, rate_energy: 16'd66, inv_sample_rate: 16'd2184
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [RATE_W-1:0]    i_cfg_data = '0;

    // predictor state
    t_cfg              rates;
    int                fast_q, slow_q, change_q, energy_q, upper_q, lower_q;
    logic [WARM_W-1:0] warm_cnt;
    logic              beat_held;
    t_out_word         expected_words[$];

    bit idle_enabled = 1'b1;
    int mismatch_count = 0;
    int cycle_count = 0;
    int stall_left = 0;

    envelope_tracker_beat_detect_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sat_q16(input longint v);
        if (v > longint'(ST_MAX)) return ST_MAX;
        if (v < longint'(ST_MIN)) return ST_MIN;
        return int'(v);
    endfunction

    function automatic int track(input longint target, input int avg,
                                 input logic [RATE_W-1:0] up, input logic [RATE_W-1:0] down);
        longint diff;
        longint rate;
        diff = target - longint'(avg);
        rate = (target > longint'(avg)) ? longint'(up) : longint'(down);
        return sat_q16(longint'(avg) + ((diff * rate) >>> RATE_W));
    endfunction

    task automatic reset_model();
        rates = RATE_DEFAULTS;
        fast_q = 0; slow_q = 0; change_q = 0; energy_q = 0; upper_q = 0; lower_q = 0;
        warm_cnt = '0;
        beat_held = 1'b0;
    endtask

    task automatic predict_sample(input t_in_word w);
        shortint   s;
        longint    x;
        longint    d;
        int        e_in;
        int        old_change;
        t_out_word r;
        s = w.sample;
        x = longint'(s) <<< FRAC_BITS;
        fast_q = track(x, fast_q, rates.rate_general, rates.rate_general);
        slow_q = track(x, slow_q, rates.rate_rise, rates.rate_fall);
        e_in = sat_q16(longint'(energy_q)
                       + ((longint'(fast_q) * longint'(rates.inv_sample_rate)) >>> RATE_W));
        energy_q = track(0, e_in, rates.rate_rise, rates.rate_energy);
        old_change = change_q;
        d = longint'(fast_q) - longint'(slow_q);
        if (d < 0) d = -d;
        if (d > longint'(ST_MAX)) d = longint'(ST_MAX);
        change_q = track(d, change_q, rates.rate_general, rates.rate_fall);
        if (change_q < 0) change_q = 0;
        // beat when old < 0.9 * new
        if (longint'(old_change) * BEAT_OLD_SCALE < longint'(change_q) * BEAT_NEW_SCALE)
            beat_held = 1'b1;
        if (warm_cnt > WARMUP_SAMPLES) begin
            upper_q = track(fast_q, upper_q, rates.rate_general, rates.rate_envelope);
            lower_q = track(fast_q, lower_q, rates.rate_envelope, rates.rate_general);
        end
        if (warm_cnt != WARM_MAX) warm_cnt++;
        r.fast_avg       = fast_q;
        r.slow_avg       = slow_q;
        r.change_level   = change_q[ST_W-2:0];
        r.energy_level   = energy_q;
        r.upper_envelope = upper_q;
        r.lower_envelope = lower_q;
        r.beat           = beat_held;
        expected_words.push_back(r);
        if (w.ack_beat) beat_held = 1'b0;
    endtask

    // called and returns at a falling edge; valid stays high for back-to-back words
    task automatic send_sample(input int value, input logic ack);
        t_in_word w;
        w.sample   = SAMPLE_BITS'(value);
        w.ack_beat = ack;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predict_sample(w);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_RATE_GENERAL:  rates.rate_general    = val;
            CFG_RATE_RISE:     rates.rate_rise       = val;
            CFG_RATE_FALL:     rates.rate_fall       = val;
            CFG_RATE_ENVELOPE: rates.rate_envelope   = val;
            CFG_RATE_ENERGY:   rates.rate_energy     = val;
            CFG_INV_RATE:      rates.inv_sample_rate = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_rates(input t_cfg r, input bit poke_spare);
        write_rate(CFG_RATE_GENERAL, r.rate_general);
        write_rate(CFG_RATE_RISE, r.rate_rise);
        write_rate(CFG_RATE_FALL, r.rate_fall);
        write_rate(CFG_RATE_ENVELOPE, r.rate_envelope);
        write_rate(CFG_RATE_ENERGY, r.rate_energy);
        write_rate(CFG_INV_RATE, r.inv_sample_rate);
        if (poke_spare) begin
            write_rate(CFG_SPARE_A, RATE_W'($urandom_range(0, 65535)));
            write_rate(CFG_SPARE_B, RATE_MAX);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [RATE_W-1:0] pick_rate(input logic [RATE_W-1:0] dflt);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return RATE_MAX;
            2:       return RATE_W'($urandom_range(0, 255));
            3:       return RATE_W'($urandom_range(0, 4095));
            4:       return RATE_W'($urandom_range(0, 65535));
            default: return dflt;
        endcase
    endfunction

    function automatic int next_sample(input int prev);
        int v;
        case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 65535) - 32768;
            1:       v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            2, 3:    v = prev;
            4, 5:    v = prev + $urandom_range(0, 511) - 256;
            default: v = $urandom_range(0, 31) - 16;
        endcase
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v;
    endfunction

    // full-scale steps, zero input, alternating bits, ack, and the end of warmup
    task automatic test_directed_samples();
        int pattern [14] = '{0, 0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1, -1,
                             21845, -21846, 0, SAMPLE_MAX, SAMPLE_MIN, 100};
        for (int i = 0; i < 14; i++)
            send_sample(pattern[i], (i == 3 || i == 5 || i == 12));
        drain_results();
    endtask

    // frozen rates, near-unity rates with spare index writes, energy saturation both ways
    task automatic test_rate_extremes();
        t_cfg r;
        load_rates('0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(0, 1'b0);
        drain_results();
        load_rates('1, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(0, 1'b0);
        drain_results();
        r = '{rate_general: RATE_MAX, rate_rise: '0, rate_fall: RATE_MAX,
              rate_envelope: '0, rate_energy: '0, inv_sample_rate: RATE_MAX};
        load_rates(r, 1'b0);
        repeat (3) send_sample(SAMPLE_MAX, 1'b0);
        repeat (4) send_sample(SAMPLE_MIN, 1'b1);
        drain_results();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        t_cfg r;
        int   level;
        level = 0;
        for (int p = 0; p < phases; p++) begin
            drain_results();
            idle_enabled = (p != phases - 1);
            if (p == 0) begin
                r = RATE_DEFAULTS;
            end else begin
                r.rate_general    = pick_rate(RATE_DEFAULTS.rate_general);
                r.rate_rise       = pick_rate(RATE_DEFAULTS.rate_rise);
                r.rate_fall       = pick_rate(RATE_DEFAULTS.rate_fall);
                r.rate_envelope   = pick_rate(RATE_DEFAULTS.rate_envelope);
                r.rate_energy     = pick_rate(RATE_DEFAULTS.rate_energy);
                r.inv_sample_rate = pick_rate(RATE_DEFAULTS.inv_sample_rate);
            end
            load_rates(r, $urandom_range(0, 2) == 0);
            for (int i = 0; i < per_phase; i++) begin
                level = next_sample(level);
                send_sample(level, $urandom_range(0, 3) == 0);
            end
        end
        drain_results();
    endtask

    task automatic compare_field(input string name, input logic [ST_W-1:0] want,
                                 input logic [ST_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        logic nxt;
        if (stall_left != 0) begin
            stall_left--;
            nxt = 1'b1;
        end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            nxt = 1'b1;
        end else begin
            nxt = 1'b0;
        end
        i_out_stall <= nxt;
    end

    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_word;
            if (expected_words.size() == 0) begin
                mismatch_count++;
                $error("output word with none outstanding: %0h", got);
            end else begin
                want = expected_words.pop_front();
                compare_field("fast_avg", want.fast_avg, got.fast_avg);
                compare_field("slow_avg", want.slow_avg, got.slow_avg);
                compare_field("change_level", ST_W'(want.change_level), ST_W'(got.change_level));
                compare_field("energy_level", want.energy_level, got.energy_level);
                compare_field("upper_envelope", want.upper_envelope, got.upper_envelope);
                compare_field("lower_envelope", want.lower_envelope, got.lower_envelope);
                compare_field("beat", ST_W'(want.beat), ST_W'(got.beat));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_samples();
        test_rate_extremes();
        test_random_phases(8, 100);
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/etbd_pkg.sv
rtl/core/etbd_seq.sv
rtl/core/etbd_dp.sv
rtl/core/envelope_tracker_beat_detect_unit.sv
verif/envelope_tracker_beat_detect_unit_test.sv
